// ----- rtl/core/kpd_pkg.sv -----
// Package: shared types, constants and helpers of the keypad press confirmer.
package kpd_pkg;

  // Fixed field widths
  localparam int unsigned LevelsW   = 10;
  localparam int unsigned KeyW      = 4;
  localparam int unsigned TickW     = 16;
  localparam int unsigned CfgIndexW = 1;

  // Defaults and codes
  localparam int unsigned SwitchCountDefault = 10;
  localparam logic [KeyW-1:0]  NoSwitch     = 4'd15;
  localparam logic [TickW-1:0] TickMax      = 16'hFFFF;
  localparam logic [TickW-1:0] LockoutReset = 16'd100;
  localparam logic [TickW-1:0] SettleReset  = 16'd100;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgLockout = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgSettle  = 1'b1;

  // Tracking state of the confirmer
  typedef struct packed {
    logic             held;
    logic [KeyW-1:0]  held_switch;
    logic [TickW-1:0] since_event;
    logic             settling;
    logic [TickW-1:0] settle_count;
    logic [KeyW-1:0]  cand_switch;
  } kpd_state_t;

  // Switch idx reads pressed; switches beyond the pins or the count read released
  function automatic logic switch_low(logic [LevelsW-1:0] levels, logic [KeyW-1:0] idx,
                                      logic [KeyW-1:0] count);
    logic [(1<<KeyW)-1:0] ext;
    ext = {{((1<<KeyW)-LevelsW){1'b1}}, levels};
    return (idx < count) && !ext[idx];
  endfunction

  // Saturating increment of a tick counter
  function automatic logic [TickW-1:0] sat_inc(logic [TickW-1:0] val);
    return (val == TickMax) ? val : val + TickW'(1);
  endfunction

endpackage

// ----- rtl/core/kpd_step.sv -----
// One-tick update: next tracking state and the result for one switch sample.
module kpd_step #(
  parameter int unsigned SwitchCount = kpd_pkg::SwitchCountDefault
) (
  input  kpd_pkg::kpd_state_t            state_i,
  input  logic [kpd_pkg::LevelsW-1:0]    levels_i,
  input  logic [kpd_pkg::TickW-1:0]      lockout_i,
  input  logic [kpd_pkg::TickW-1:0]      settle_i,
  output kpd_pkg::kpd_state_t            state_o,
  output logic [kpd_pkg::KeyW-1:0]       key_code_o,
  output logic                           buzzer_pulse_o
);
  import kpd_pkg::*;

  localparam logic [KeyW-1:0] Count = KeyW'(SwitchCount);

  logic [(1<<KeyW)-1:0] ext;
  logic                 found;
  logic [KeyW-1:0]      first_idx;
  logic [TickW-1:0]     since_inc;

  // Lowest-indexed pressed switch
  always_comb begin
    ext       = {{((1<<KeyW)-LevelsW){1'b1}}, levels_i};
    found     = 1'b0;
    first_idx = '0;
    for (int i = SwitchCount - 1; i >= 0; i--) begin
      if (!ext[i]) begin
        found     = 1'b1;
        first_idx = KeyW'(i);
      end
    end
  end

  assign since_inc = sat_inc(state_i.since_event);

  // State update for one tick
  always_comb begin
    state_o             = state_i;
    state_o.since_event = since_inc;
    key_code_o          = Count;
    buzzer_pulse_o      = 1'b0;
    if (state_i.held) begin
      // held: wait for the held switch to come back up
      if (!switch_low(levels_i, state_i.held_switch, Count)) begin
        state_o.held        = 1'b0;
        state_o.held_switch = NoSwitch;
        state_o.since_event = '0;
      end
    end else begin
      // released: take a candidate or advance the settle count
      if (!state_i.settling && (since_inc >= lockout_i)) begin
        if (found) begin
          state_o.cand_switch  = first_idx;
          state_o.settling     = 1'b1;
          state_o.settle_count = '0;
        end
      end else if (state_i.settling) begin
        state_o.settle_count = sat_inc(state_i.settle_count);
      end
      // confirmation check, same tick when settle time is zero
      if (state_o.settling && (state_o.settle_count >= settle_i)) begin
        state_o.settling = 1'b0;
        if (switch_low(levels_i, state_o.cand_switch, Count)) begin
          state_o.held        = 1'b1;
          state_o.held_switch = state_o.cand_switch;
          state_o.since_event = '0;
          key_code_o          = state_o.cand_switch;
          buzzer_pulse_o      = 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/keypad_press_confirm_debouncer_core.sv -----
// Top level: keypad press confirmer with input register, step logic and result register.
// Each transfer on the input carries one millisecond sample of the switch pins and yields
// exactly one result transfer: key_code is the index of a newly confirmed press (or
// SWITCH_COUNT when there is none) and buzzer_pulse is high on that same result. The block
// takes one sample per cycle while its input is not stalled; a result is presented once its
// sample has passed through the input register and the single-pass step logic into the
// result register. A held output stalls the input side only once both registers are full.
// lockout_ticks and settle_ticks are written through the cfg port only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
module keypad_press_confirm_debouncer_core #(
  parameter int unsigned SWITCH_COUNT = kpd_pkg::SwitchCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kpd_pkg::LevelsW-1:0]     switch_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kpd_pkg::KeyW-1:0]        key_code_o,
  output logic                            buzzer_pulse_o,
  input  logic                            cfg_we_i,
  input  logic [kpd_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [kpd_pkg::TickW-1:0]       cfg_wdata_i
);
  import kpd_pkg::*;

  logic               in_valid_q;
  logic [LevelsW-1:0] levels_q;
  logic               out_valid_q;
  logic [KeyW-1:0]    key_code_q;
  logic               buzzer_pulse_q;
  logic [TickW-1:0]   lockout_q;
  logic [TickW-1:0]   settle_q;
  kpd_state_t         state_q;
  kpd_state_t         state_d;
  logic [KeyW-1:0]    key_code_d;
  logic               buzzer_pulse_d;
  logic               out_free;
  logic               advance;
  logic               in_take;

  // Handshake: result register frees when empty or drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LockoutReset;
      settle_q  <= SettleReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLockout: lockout_q <= cfg_wdata_i;
        CfgSettle:  settle_q  <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      levels_q <= switch_levels_i;
    end
  end

  // Step logic
  kpd_step #(
    .SwitchCount (SWITCH_COUNT)
  ) u_step (
    .state_i        (state_q),
    .levels_i       (levels_q),
    .lockout_i      (lockout_q),
    .settle_i       (settle_q),
    .state_o        (state_d),
    .key_code_o     (key_code_d),
    .buzzer_pulse_o (buzzer_pulse_d)
  );

  // Tracking state, updated as each sample moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.held         <= 1'b0;
      state_q.held_switch  <= NoSwitch;
      state_q.since_event  <= '0;
      state_q.settling     <= 1'b0;
      state_q.settle_count <= '0;
      state_q.cand_switch  <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      key_code_q     <= key_code_d;
      buzzer_pulse_q <= buzzer_pulse_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_code_o     = key_code_q;
  assign buzzer_pulse_o = buzzer_pulse_q;

`ifndef ASSERT_OFF
  // A held switch is always a real switch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held |-> (state_q.held_switch < KeyW'(SWITCH_COUNT)))
    else $error("held switch index out of range");

  // Holding and settling never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.held && state_q.settling))
    else $error("held and settling at once");

  // Beep goes with a reported key and only then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (buzzer_pulse_q == (key_code_q != KeyW'(SWITCH_COUNT))))
    else $error("buzzer pulse and key code disagree");

  // A confirmed press enters the held state on that same transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && buzzer_pulse_d) |=> state_q.held)
    else $error("confirmed press did not enter held state");
`endif

endmodule
